// ===== src/lrs_pkg.sv =====
// Shared types, command codes and constants of the locomotive refresh scheduler.
package lrs_pkg;

  localparam int MM_LIST_DEPTH_DEF  = 128;
  localparam int DCC_LIST_DEPTH_DEF = 256;

  localparam int MM_ADDR_W  = 8;
  localparam int DCC_ADDR_W = 14;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Speed packet plus four function packets, speed plus one function packet.
  localparam int MM_SLOTS  = 5;
  localparam int DCC_SLOTS = 2;

  localparam logic [MM_ADDR_W-1:0]  MM_IDLE  = MM_ADDR_W'(81);
  localparam logic [DCC_ADDR_W-1:0] DCC_IDLE = DCC_ADDR_W'(255);

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG_MM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REG_DCC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MM_EN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DCC_EN = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [DCC_ADDR_W-1:0] addr;
  } in_word_t;

  typedef struct packed {
    logic                  mm_valid;
    logic [MM_ADDR_W-1:0]  mm_addr;
    logic [2:0]            mm_slot;
    logic                  dcc_valid;
    logic [DCC_ADDR_W-1:0] dcc_addr;
    logic                  dcc_slot;
    logic                  rejected;
  } out_word_t;

endpackage

// ===== src/lrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lrs_cursor.sv =====
// Round-robin cursor over one address list: entry index and packet slot.
module lrs_cursor #(
  parameter int DEPTH = 128,
  parameter int SLOTS = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH)-1:0]   index,
  output logic [$clog2(SLOTS)-1:0]   phase
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PH_W  = $clog2(SLOTS);

  logic [IDX_W-1:0] index_r, index_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [IDX_W:0]   index_inc;

  always_comb begin
    index_nxt = index_r;
    phase_nxt = phase_r;
    index_inc = {1'b0, index_r} + (IDX_W+1)'(1);
    if (advance) begin
      if (phase_r == PH_W'(SLOTS - 1)) begin
        phase_nxt = '0;
        // wrap past the last entry in use
        if (index_inc >= (IDX_W+1)'(count)) begin
          index_nxt = '0;
        end else begin
          index_nxt = index_inc[IDX_W-1:0];
        end
      end else begin
        phase_nxt = phase_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      phase_r <= '0;
    end else begin
      index_r <= index_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign index = index_r;
  assign phase = phase_r;

endmodule

// ===== src/loco_refresh_scheduler.sv =====
// Locomotive refresh scheduler: two address lists, serial registration search, tick selection.
// Refresh tick: accept, list RAM read, then select into the result register.
// Registration walks the list with one shared comparator, a read state then a compare state
// per entry in use; the result strobe rises as busy drops.
// An unknown command returns an all-zero word in the cycle after accept. Throughput: one word
// per command once busy drops; the receiver cannot stall the result strobe.
// Reset (synchronous, rst_n low): both lists hold only their idle entry, cursors at zero,
// both formats enabled; entry zero lives in a flop, so no clearing pass is needed.
module loco_refresh_scheduler
  import lrs_pkg::*;
#(
  parameter int MM_LIST_DEPTH  = MM_LIST_DEPTH_DEF,
  parameter int DCC_LIST_DEPTH = DCC_LIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MM_AW  = $clog2(MM_LIST_DEPTH);
  localparam int DCC_AW = $clog2(DCC_LIST_DEPTH);
  localparam int MM_CW  = $clog2(MM_LIST_DEPTH + 1);
  localparam int DCC_CW = $clog2(DCC_LIST_DEPTH + 1);
  localparam int SW     = (MM_CW > DCC_CW) ? MM_CW : DCC_CW;
  localparam int MM_PW  = $clog2(MM_SLOTS);
  localparam int DCC_PW = $clog2(DCC_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_TICK = 2'd3;

  logic [1:0] st_r, st_nxt;

  // configuration
  logic mm_en_r, dcc_en_r;

  // list state
  logic [MM_ADDR_W-1:0]  mm_head_r, mm_head_nxt;
  logic [DCC_ADDR_W-1:0] dcc_head_r, dcc_head_nxt;
  logic [MM_CW-1:0]      mm_count_r, mm_count_nxt;
  logic [DCC_CW-1:0]     dcc_count_r, dcc_count_nxt;
  logic                  alt_r, alt_nxt;

  // search context
  logic                  sel_dcc_r, sel_dcc_nxt;
  logic [DCC_ADDR_W-1:0] key_r, key_nxt;
  logic [SW-1:0]         srch_r, srch_nxt;

  // result register
  logic      out_strobe_r, out_strobe_nxt;
  out_word_t out_word_r, out_word_nxt;

  // RAM and cursor wires
  logic                  mm_we, dcc_we;
  logic [MM_AW-1:0]      mm_raddr;
  logic [DCC_AW-1:0]     dcc_raddr;
  logic [MM_ADDR_W-1:0]  mm_q;
  logic [DCC_ADDR_W-1:0] dcc_q;
  logic [MM_AW-1:0]      mm_idx;
  logic [DCC_AW-1:0]     dcc_idx;
  logic [MM_PW-1:0]      mm_ph;
  logic [DCC_PW-1:0]     dcc_ph;
  logic                  mm_adv, dcc_adv;

  // shared search datapath
  logic                  accept;
  logic [SW-1:0]         cur_count, eff_count, cur_depth;
  logic [DCC_ADDR_W-1:0] cur_head, cur_idle, cmp_data;
  logic                  match, lone, fin, found, full, do_write;
  logic                  do_mm, do_dcc;
  logic [MM_ADDR_W-1:0]  mm_tick_addr;
  logic [DCC_ADDR_W-1:0] dcc_tick_addr;

  assign accept    = start && !busy;
  assign busy      = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_en_r  <= 1'b1;
      dcc_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MM_EN:  mm_en_r  <= cfg_data[0];
        CFG_DCC_EN: dcc_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the search index on the RAM in the read state of a registration, the cursors otherwise.
  assign mm_raddr  = (st_r == ST_RD) ? srch_r[MM_AW-1:0] : mm_idx;
  assign dcc_raddr = (st_r == ST_RD) ? srch_r[DCC_AW-1:0] : dcc_idx;

  // Entry zero comes from its flop, since the RAM copy is unwritten after reset.
  assign mm_tick_addr  = (mm_idx == '0) ? mm_head_r : mm_q;
  assign dcc_tick_addr = (dcc_idx == '0) ? dcc_head_r : dcc_q;

  always_comb begin
    cur_count = sel_dcc_r ? SW'(dcc_count_r) : SW'(mm_count_r);
    cur_depth = sel_dcc_r ? SW'(DCC_LIST_DEPTH) : SW'(MM_LIST_DEPTH);
    cur_head  = sel_dcc_r ? dcc_head_r : DCC_ADDR_W'(mm_head_r);
    cur_idle  = sel_dcc_r ? DCC_IDLE : DCC_ADDR_W'(MM_IDLE);
    if (srch_r == '0) begin
      cmp_data = cur_head;
    end else begin
      cmp_data = sel_dcc_r ? dcc_q : DCC_ADDR_W'(mm_q);
    end
    // the one shared comparator of the search loop
    match = (cmp_data == key_r);
    fin   = ((st_r == ST_RD) && (srch_r >= cur_count)) || ((st_r == ST_CMP) && match);
    found = (st_r == ST_CMP);
    // drop the lone idle entry when a registration ends
    lone      = (cur_count == SW'(1)) && (cur_head == cur_idle);
    eff_count = lone ? '0 : cur_count;
    full      = !found && (eff_count >= cur_depth);
    do_write  = fin && !found && !full;
    do_mm     = mm_en_r && (alt_r || !dcc_en_r);
    do_dcc    = dcc_en_r && (!alt_r || !mm_en_r);
  end

  assign mm_we   = do_write && !sel_dcc_r;
  assign dcc_we  = do_write && sel_dcc_r;
  assign mm_adv  = (st_r == ST_TICK) && do_mm;
  assign dcc_adv = (st_r == ST_TICK) && do_dcc;

  always_comb begin
    st_nxt         = st_r;
    sel_dcc_nxt    = sel_dcc_r;
    key_nxt        = key_r;
    srch_nxt       = srch_r;
    mm_head_nxt    = mm_head_r;
    dcc_head_nxt   = dcc_head_r;
    mm_count_nxt   = mm_count_r;
    dcc_count_nxt  = dcc_count_r;
    alt_nxt        = alt_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          srch_nxt = '0;
          if (in_word.cmd == CMD_TICK) begin
            st_nxt = ST_TICK;
          end else if (in_word.cmd == CMD_REG_MM) begin
            sel_dcc_nxt = 1'b0;
            key_nxt     = DCC_ADDR_W'(in_word.addr[MM_ADDR_W-1:0]);
            st_nxt      = ST_RD;
          end else if (in_word.cmd == CMD_REG_DCC) begin
            sel_dcc_nxt = 1'b1;
            key_nxt     = in_word.addr;
            st_nxt      = ST_RD;
          end else begin
            // unknown command: answer with an all-zero word
            out_strobe_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (!fin) begin
          st_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!fin) begin
          srch_nxt = srch_r + SW'(1);
          st_nxt   = ST_RD;
        end
      end
      ST_TICK: begin
        out_strobe_nxt = 1'b1;
        if (do_mm) begin
          out_word_nxt.mm_valid = 1'b1;
          out_word_nxt.mm_addr  = mm_tick_addr;
          out_word_nxt.mm_slot  = 3'(mm_ph);
        end
        if (do_dcc) begin
          out_word_nxt.dcc_valid = 1'b1;
          out_word_nxt.dcc_addr  = dcc_tick_addr;
          out_word_nxt.dcc_slot  = dcc_ph[0];
        end
        alt_nxt = !alt_r;
        st_nxt  = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (fin) begin
      out_strobe_nxt        = 1'b1;
      out_word_nxt.rejected = full;
      st_nxt                = ST_IDLE;
      if (sel_dcc_r) begin
        dcc_count_nxt = DCC_CW'(eff_count + SW'(do_write));
        if (do_write && (eff_count == '0)) begin
          dcc_head_nxt = key_r;
        end
      end else begin
        mm_count_nxt = MM_CW'(eff_count + SW'(do_write));
        if (do_write && (eff_count == '0)) begin
          mm_head_nxt = key_r[MM_ADDR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      mm_head_r    <= MM_IDLE;
      dcc_head_r   <= DCC_IDLE;
      mm_count_r   <= MM_CW'(1);
      dcc_count_r  <= DCC_CW'(1);
      alt_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      mm_head_r    <= mm_head_nxt;
      dcc_head_r   <= dcc_head_nxt;
      mm_count_r   <= mm_count_nxt;
      dcc_count_r  <= dcc_count_nxt;
      alt_r        <= alt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_dcc_r  <= sel_dcc_nxt;
    key_r      <= key_nxt;
    srch_r     <= srch_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  lrs_ram #(
    .WIDTH (MM_ADDR_W),
    .DEPTH (MM_LIST_DEPTH)
  ) u_mm_ram (
    .clk   (clk),
    .we    (mm_we),
    .waddr (eff_count[MM_AW-1:0]),
    .wdata (key_r[MM_ADDR_W-1:0]),
    .raddr (mm_raddr),
    .rdata (mm_q)
  );

  lrs_ram #(
    .WIDTH (DCC_ADDR_W),
    .DEPTH (DCC_LIST_DEPTH)
  ) u_dcc_ram (
    .clk   (clk),
    .we    (dcc_we),
    .waddr (eff_count[DCC_AW-1:0]),
    .wdata (key_r),
    .raddr (dcc_raddr),
    .rdata (dcc_q)
  );

  lrs_cursor #(
    .DEPTH (MM_LIST_DEPTH),
    .SLOTS (MM_SLOTS)
  ) u_mm_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (mm_adv),
    .count   (mm_count_r),
    .index   (mm_idx),
    .phase   (mm_ph)
  );

  lrs_cursor #(
    .DEPTH (DCC_LIST_DEPTH),
    .SLOTS (DCC_SLOTS)
  ) u_dcc_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (dcc_adv),
    .count   (dcc_count_r),
    .index   (dcc_idx),
    .phase   (dcc_ph)
  );

  // A tick always ends in a result word the next cycle.
  a_tick_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TICK) |=> out_strobe)
    else $error("tick did not produce a result word");

  // Refusal only comes from a registration, never alongside a packet pick.
  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.rejected) |-> (!out_word.mm_valid && !out_word.dcc_valid))
    else $error("rejected word carries a packet selection");

  // Fill counts stay within the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (MM_CW'(MM_LIST_DEPTH) >= mm_count_r) && (DCC_CW'(DCC_LIST_DEPTH) >= dcc_count_r))
    else $error("list fill count beyond depth");

  // Cursors only point at entries in use, or at entry zero.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TICK) |-> (((MM_CW'(mm_idx) < mm_count_r) || (mm_idx == '0))
      && ((DCC_CW'(dcc_idx) < dcc_count_r) || (dcc_idx == '0))))
    else $error("refresh cursor beyond the entries in use");

endmodule
